// ----- rtl/cnsm_pkg.sv -----
`default_nettype none
package cnsm_pkg;

  localparam int CAPACITY   = 1024;
  localparam int SCORE_W    = 20;
  localparam int ID_W       = 31;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE = (CAPACITY < 32) ? CAPACITY : 32;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [SCORE_W-1:0] CALIPER_RESET = SCORE_W'(50000);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_MATCH = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LOADED  = 3'd0,
    STATUS_FULL    = 3'd1,
    STATUS_MATCHED = 3'd2,
    STATUS_OUTSIDE = 3'd3,
    STATUS_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER,
    ST_COMMIT
  } state_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic load;
    logic find;
    logic remove;
  } cell_op_t;

endpackage
`default_nettype wire

// ----- rtl/caliper_nearest_score_matcher_core.sv -----
`default_nettype none
// A load word, or a match word on an empty store, gives its result from the exec step;
// any other match word passes through the find, gather and commit steps first.
// A new word is taken only while busy is low, so it waits until the last result is out.
// The result strobe out_valid lasts one cycle and cannot be held off by the receiver.
// Reset (rst_n low, synchronous) empties the store and sets the caliper to 50000.
module caliper_nearest_score_matcher_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [cnsm_pkg::SCORE_W-1:0]  in_score,
  input  wire logic [cnsm_pkg::ID_W-1:0]     in_treated_id,
  output logic                               out_valid,
  output logic      [cnsm_pkg::STATUS_W-1:0] out_status,
  output logic      [cnsm_pkg::ID_W-1:0]     out_pair_id,
  output logic      [cnsm_pkg::SCORE_W-1:0]  out_control_score,
  input  wire logic                          cfg_write_en,
  input  wire logic [cnsm_pkg::SCORE_W-1:0]  cfg_write_data
);

  // The store is a row of cells held in ascending order. Cell i holds a live
  // score when i is below the entry count. Each cell compares its score
  // against the broadcast key and talks only to its two neighbors:
  //  - A load shifts every cell above the insertion point up by one. The cell
  //    whose left neighbor is not greater than the key takes the key when it
  //    is greater itself or holds no live score.
  //  - A find lets each cell decide locally whether it is the nearest entry,
  //    since the two candidates are neighbors. The winner offers its score.
  //  - The offered score is OR-collected in a registered two-level tree.
  //  - The commit step checks the distance against the caliper and, on a
  //    match, shifts every cell at or above the winner down by one.

  cnsm_pkg::state_t state_r, state_nxt;
  logic [cnsm_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [cnsm_pkg::SCORE_W-1:0] caliper_r;
  logic [cnsm_pkg::SCORE_W-1:0] key_r, key_nxt;
  logic [cnsm_pkg::ID_W-1:0]    id_r, id_nxt;
  cnsm_pkg::cmd_t               cmd_r, cmd_nxt;

  logic                         out_valid_r, out_valid_nxt;
  cnsm_pkg::status_t            out_status_r, out_status_nxt;
  logic [cnsm_pkg::ID_W-1:0]    out_pair_id_r, out_pair_id_nxt;
  logic [cnsm_pkg::SCORE_W-1:0] out_score_r, out_score_nxt;

  cnsm_pkg::cell_op_t           cell_op;
  logic                         gather_en;
  logic [cnsm_pkg::SCORE_W-1:0] picked, score_gap;
  logic                         near_enough;

  logic [cnsm_pkg::SCORE_W-1:0] cell_score [cnsm_pkg::CAPACITY];
  logic [cnsm_pkg::SCORE_W-1:0] cell_sel   [cnsm_pkg::CAPACITY];
  logic [cnsm_pkg::CAPACITY-1:0] cell_valid, cell_ge, cell_gt;

  // The chain of cells with its neighbor links.
  for (genvar i = 0; i < cnsm_pkg::CAPACITY; i++) begin : g_cell
    logic                         l_valid, l_ge, l_gt, r_valid, r_ge;
    logic [cnsm_pkg::SCORE_W-1:0] l_score, r_score;

    assign cell_valid[i] = cnsm_pkg::CNT_W'(i) < count_r;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_ge    = 1'b0;
      assign l_gt    = 1'b0;
      assign l_score = '0;
    end else begin : g_left
      assign l_valid = cell_valid[i-1];
      assign l_ge    = cell_ge[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_score = cell_score[i-1];
    end

    if (i == cnsm_pkg::CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_ge    = 1'b0;
      assign r_score = '0;
    end else begin : g_right
      assign r_valid = cell_valid[i+1];
      assign r_ge    = cell_ge[i+1];
      assign r_score = cell_score[i+1];
    end

    cnsm_cell u_cell (
      .clk         (clk),
      .op          (cell_op),
      .key         (key_r),
      .valid       (cell_valid[i]),
      .left_valid  (l_valid),
      .left_ge     (l_ge),
      .left_gt     (l_gt),
      .left_score  (l_score),
      .right_valid (r_valid),
      .right_ge    (r_ge),
      .right_score (r_score),
      .score       (cell_score[i]),
      .ge          (cell_ge[i]),
      .gt          (cell_gt[i]),
      .sel_score   (cell_sel[i])
    );
  end

  cnsm_gather u_gather (
    .clk    (clk),
    .en     (gather_en),
    .sel    (cell_sel),
    .picked (picked)
  );

  // Distance of the nearest entry against the caliper.
  always_comb begin
    score_gap   = (picked > key_r) ? (picked - key_r) : (key_r - picked);
    near_enough = score_gap <= caliper_r;
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    key_nxt         = key_r;
    id_nxt          = id_r;
    cmd_nxt         = cmd_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_pair_id_nxt = out_pair_id_r;
    out_score_nxt   = out_score_r;
    cell_op         = '0;
    gather_en       = 1'b0;

    unique case (state_r)
      cnsm_pkg::ST_IDLE: begin
        if (start) begin
          key_nxt   = in_score;
          id_nxt    = in_treated_id;
          cmd_nxt   = cnsm_pkg::cmd_t'(in_command);
          state_nxt = cnsm_pkg::ST_EXEC;
        end
      end
      cnsm_pkg::ST_EXEC: begin
        if (cmd_r == cnsm_pkg::CMD_LOAD) begin
          out_valid_nxt   = 1'b1;
          out_pair_id_nxt = '0;
          out_score_nxt   = '0;
          state_nxt       = cnsm_pkg::ST_IDLE;
          if (count_r == cnsm_pkg::CNT_W'(cnsm_pkg::CAPACITY)) begin
            out_status_nxt = cnsm_pkg::STATUS_FULL;
          end else begin
            cell_op.load   = 1'b1;
            count_nxt      = count_r + cnsm_pkg::CNT_W'(1);
            out_status_nxt = cnsm_pkg::STATUS_LOADED;
          end
        end else if (count_r == '0) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = cnsm_pkg::STATUS_EMPTY;
          out_pair_id_nxt = '0;
          out_score_nxt   = '0;
          state_nxt       = cnsm_pkg::ST_IDLE;
        end else begin
          cell_op.find = 1'b1;
          state_nxt    = cnsm_pkg::ST_GATHER;
        end
      end
      cnsm_pkg::ST_GATHER: begin
        gather_en = 1'b1;
        state_nxt = cnsm_pkg::ST_COMMIT;
      end
      cnsm_pkg::ST_COMMIT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = cnsm_pkg::ST_IDLE;
        if (near_enough) begin
          cell_op.remove  = 1'b1;
          count_nxt       = count_r - cnsm_pkg::CNT_W'(1);
          out_status_nxt  = cnsm_pkg::STATUS_MATCHED;
          out_pair_id_nxt = id_r;
          out_score_nxt   = picked;
        end else begin
          out_status_nxt  = cnsm_pkg::STATUS_OUTSIDE;
          out_pair_id_nxt = '0;
          out_score_nxt   = '0;
        end
      end
      default: begin
        state_nxt = cnsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnsm_pkg::ST_IDLE;
      count_r     <= '0;
      caliper_r   <= cnsm_pkg::CALIPER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        caliper_r <= cfg_write_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    id_r          <= id_nxt;
    cmd_r         <= cmd_nxt;
    out_status_r  <= out_status_nxt;
    out_pair_id_r <= out_pair_id_nxt;
    out_score_r   <= out_score_nxt;
  end

  assign busy              = (state_r != cnsm_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_pair_id       = out_pair_id_r;
  assign out_control_score = out_score_r;

endmodule
`default_nettype wire

// ----- rtl/cnsm_cell.sv -----
`default_nettype none
module cnsm_cell (
  input  wire logic                         clk,
  input  wire cnsm_pkg::cell_op_t           op,
  input  wire logic [cnsm_pkg::SCORE_W-1:0] key,
  input  wire logic                         valid,
  input  wire logic                         left_valid,
  input  wire logic                         left_ge,
  input  wire logic                         left_gt,
  input  wire logic [cnsm_pkg::SCORE_W-1:0] left_score,
  input  wire logic                         right_valid,
  input  wire logic                         right_ge,
  input  wire logic [cnsm_pkg::SCORE_W-1:0] right_score,
  output logic      [cnsm_pkg::SCORE_W-1:0] score,
  output logic                              ge,
  output logic                              gt,
  output logic      [cnsm_pkg::SCORE_W-1:0] sel_score
);

  logic [cnsm_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic [cnsm_pkg::SCORE_W-1:0] sel_r, sel_nxt;
  logic                         del_r, del_nxt;
  logic                         is_below, is_above, below_wins, above_wins, pick;

  assign score     = score_r;
  assign sel_score = sel_r;
  assign ge        = valid & (score_r >= key);
  assign gt        = valid & (score_r > key);

  // The cell just below the key takes the match on a strictly smaller
  // distance; the cell at or above the key takes it on a tie.
  always_comb begin
    is_below   = valid & ~ge & (right_ge | ~right_valid);
    below_wins = ~right_valid | ((key - score_r) < (right_score - key));
    is_above   = ge & ~left_ge;
    above_wins = ~left_valid | ~((key - left_score) < (score_r - key));
    pick       = (is_below & below_wins) | (is_above & above_wins);
  end

  always_comb begin
    score_nxt = score_r;
    sel_nxt   = sel_r;
    del_nxt   = del_r;
    if (op.load) begin
      if (left_gt) begin
        score_nxt = left_score;
      end else if (gt | ~valid) begin
        score_nxt = key;
      end
    end
    if (op.find) begin
      sel_nxt = pick ? score_r : '0;
      del_nxt = ge | pick;
    end
    if (op.remove && del_r) begin
      score_nxt = right_score;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    sel_r   <= sel_nxt;
    del_r   <= del_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/cnsm_gather.sv -----
`default_nettype none
module cnsm_gather (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [cnsm_pkg::SCORE_W-1:0] sel [cnsm_pkg::CAPACITY],
  output logic      [cnsm_pkg::SCORE_W-1:0] picked
);

  localparam int PAD = cnsm_pkg::NUM_GROUPS * cnsm_pkg::GROUP_SIZE;

  logic [cnsm_pkg::SCORE_W-1:0] pad [PAD];
  logic [cnsm_pkg::SCORE_W-1:0] group_r   [cnsm_pkg::NUM_GROUPS];
  logic [cnsm_pkg::SCORE_W-1:0] group_nxt [cnsm_pkg::NUM_GROUPS];

  for (genvar j = 0; j < PAD; j++) begin : g_pad
    if (j < cnsm_pkg::CAPACITY) begin : g_real
      assign pad[j] = sel[j];
    end else begin : g_zero
      assign pad[j] = '0;
    end
  end

  // At most one cell offers a nonzero word, so a plain OR collects it.
  always_comb begin
    for (int g = 0; g < cnsm_pkg::NUM_GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int k = 0; k < cnsm_pkg::GROUP_SIZE; k++) begin
        group_nxt[g] = group_nxt[g] | pad[g * cnsm_pkg::GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      group_r <= group_nxt;
    end
  end

  always_comb begin
    picked = '0;
    for (int g = 0; g < cnsm_pkg::NUM_GROUPS; g++) begin
      picked = picked | group_r[g];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cnsm_checker.sv -----
`default_nettype none
module cnsm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [cnsm_pkg::STATUS_W-1:0] out_status,
  input wire logic [cnsm_pkg::ID_W-1:0]     out_pair_id,
  input wire logic [cnsm_pkg::SCORE_W-1:0]  out_control_score
);

  // A taken word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // Every end of work delivers a result as busy falls.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("work ended without a result");

  // A result only shows once the block is idle again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'(cnsm_pkg::STATUS_EMPTY)))
    else $error("undefined status code");

  // Only a match carries a pair identifier and a control score.
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 3'(cnsm_pkg::STATUS_MATCHED))
      |-> (out_pair_id == '0) && (out_control_score == '0))
    else $error("nonzero payload on a result that is not a match");

endmodule

bind caliper_nearest_score_matcher_core cnsm_checker u_cnsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_pair_id       (out_pair_id),
  .out_control_score (out_control_score)
);
`default_nettype wire
